// ===== sv/rdk_pkg.sv =====
`timescale 1ns / 1ps

package rdk_pkg;

  typedef struct packed {
    logic [63:0] rec_key;
    logic [63:0] rec_value;
    logic        end_of_set;
  } rec_in_t;

  typedef struct packed {
    logic [63:0] out_key;
    logic [63:0] out_value;
    logic        last_of_run;
    logic        overflowed;
  } rec_out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  localparam logic MODE_KEEP_FIRST = 1'b0;
  localparam logic MODE_KEEP_LAST  = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_FL_RD = 7'b0100000,
    S_FL_LD = 7'b1000000
  } state_t;

endpackage

// ===== sv/record_dedup_by_key_top.sv =====
`timescale 1ns / 1ps

// per record: the single key comparator scans the entry memory one read per cycle, and a new
//   record is not accepted until the last one is done; a repeat ends the scan at its hit, and
//   a keep-last repeat then shifts the entries above it
// keep-last flush: each held entry is read (S_FL_RD), then loaded into the output stage (S_FL_LD) once it is free
// reset: synchronous active-low rst_n clears count, overflow flag, mode, sequencer, output valid
module record_dedup_by_key_top #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdk_pkg::rec_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rdk_pkg::rec_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import rdk_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          keep_mode_r;
  logic          out_valid_r;
  rec_out_t      out_data_r;
  logic          out_free;
  logic          out_load;
  rec_out_t      out_item;
  mem_ctl_t      mctl;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rdata;

  assign out_free = !out_valid_r || out_ready;

  rdk_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .keep_mode(keep_mode_r),
    .out_free (out_free),
    .out_load (out_load),
    .out_item (out_item),
    .mctl     (mctl),
    .raddr    (raddr),
    .waddr    (waddr),
    .wdata    (wdata),
    .rdata    (rdata)
  );

  rdk_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .mctl (mctl),
    .raddr(raddr),
    .waddr(waddr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_mode_r <= MODE_KEEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_mode_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output stage, holds a finished transaction while the input side moves on
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/rdk_mem.sv =====
`timescale 1ns / 1ps

module rdk_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  rdk_pkg::mem_ctl_t mctl,
  input  logic [AW-1:0]    raddr,
  input  logic [AW-1:0]    waddr,
  input  rdk_pkg::entry_t  wdata,
  output rdk_pkg::entry_t  rdata
);
  import rdk_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (mctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (mctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rdk_ctrl.sv =====
`timescale 1ns / 1ps

module rdk_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rdk_pkg::rec_in_t  in_data,
  input  logic              keep_mode,
  input  logic              out_free,
  output logic              out_load,
  output rdk_pkg::rec_out_t out_item,
  output rdk_pkg::mem_ctl_t mctl,
  output logic [AW-1:0]     raddr,
  output logic [AW-1:0]     waddr,
  output rdk_pkg::entry_t   wdata,
  input  rdk_pkg::entry_t   rdata
);
  import rdk_pkg::*;

  state_t        state_r, state_nxt;
  rec_in_t       rec_r, rec_nxt;
  logic          mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          pv_r, pv_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          found_r, found_nxt;

  logic          issue;
  logic          match;
  logic          finish;
  logic [CW-1:0] cnt_m1;
  logic          fl_last;

  assign issue   = ptr_r < cnt_r;
  assign match   = pv_r && (rdata.key == rec_r.rec_key);
  assign cnt_m1  = cnt_r - CW'(1);
  assign fl_last = ptr_r == cnt_m1;

  always_comb begin
    state_nxt = state_r;
    rec_nxt   = rec_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    ptr_nxt   = ptr_r;
    pv_nxt    = 1'b0;
    pidx_nxt  = pidx_r;
    found_nxt = found_r;
    finish    = 1'b0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    out_item  = '0;
    mctl      = '0;
    raddr     = ptr_r[AW-1:0];
    waddr     = cnt_r[AW-1:0];
    wdata     = '{key: rec_r.rec_key, value: rec_r.rec_value};

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rec_nxt   = in_data;
          mode_nxt  = keep_mode;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        // one stored key per cycle through the single comparator
        mctl.rd_en = issue;
        pv_nxt     = issue;
        pidx_nxt   = ptr_r[AW-1:0];
        if (issue) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (match) begin
          pv_nxt = 1'b0;
          if (mode_r == MODE_KEEP_LAST) begin
            found_nxt = 1'b1;
            ptr_nxt   = CW'(pidx_r) + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            finish = 1'b1;
          end
        end else if (!issue && !pv_r) begin
          if (cnt_r < CW'(DEPTH)) begin
            state_nxt = S_WRITE;
          end else begin
            ovf_nxt = 1'b1;
            finish  = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // move entries above the hit down by one
        mctl.rd_en = issue;
        pv_nxt     = issue;
        pidx_nxt   = ptr_r[AW-1:0];
        if (issue) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (pv_r) begin
          mctl.wr_en = 1'b1;
          waddr      = pidx_r - AW'(1);
          wdata      = rdata;
        end else if (!issue) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        mctl.wr_en = 1'b1;
        waddr      = found_r ? cnt_m1[AW-1:0] : cnt_r[AW-1:0];
        if (!found_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (mode_r == MODE_KEEP_FIRST) begin
          state_nxt = S_EMIT;
        end else begin
          finish = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_item  = '{out_key: rec_r.rec_key, out_value: rec_r.rec_value,
                        last_of_run: rec_r.end_of_set, overflowed: ovf_r};
          finish    = 1'b1;
        end
      end
      S_FL_RD: begin
        if (issue) begin
          mctl.rd_en = 1'b1;
          state_nxt  = S_FL_LD;
        end else begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_FL_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          out_item = '{out_key: rdata.key, out_value: rdata.value,
                       last_of_run: fl_last, overflowed: ovf_r};
          ptr_nxt  = ptr_r + CW'(1);
          if (fl_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      if (rec_r.end_of_set && (mode_r == MODE_KEEP_LAST)) begin
        ptr_nxt   = '0;
        state_nxt = S_FL_RD;
      end else begin
        if (rec_r.end_of_set) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      pv_r    <= pv_nxt;
      found_r <= found_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    mode_r <= mode_nxt;
    pidx_r <= pidx_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CW'(DEPTH))
    else $error("overflow flag set with free entries");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded into busy output stage");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_item.last_of_run |=> cnt_r == '0 && !ovf_r)
    else $error("set state not cleared after last transaction");
`endif

endmodule
